// File: design/ppm_pkg.sv
// Shared types and constants for the PPM P6 stream parser.
// Depends on nothing; every other design file imports it.
`default_nettype none

package ppm_pkg;

  localparam int DATA_W   = 8;
  localparam int KIND_W   = 2;
  localparam int DIM_W    = 13;
  localparam int SAMPLE_W = 16;
  localparam int COORD_W  = 12;
  localparam int FIELD_W  = 2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_HEADER    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PIXEL     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BAD_MAGIC = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SIZE_ERR  = 2'd3;

  // Header number being parsed.
  localparam logic [FIELD_W-1:0] FLD_WIDTH  = 2'd0;
  localparam logic [FIELD_W-1:0] FLD_HEIGHT = 2'd1;
  localparam logic [FIELD_W-1:0] FLD_MAXVAL = 2'd2;
  localparam logic [FIELD_W-1:0] FLD_DONE   = 2'd3;

  // Characters of interest in the file stream.
  localparam logic [DATA_W-1:0] CH_P    = 8'h50;
  localparam logic [DATA_W-1:0] CH_6    = 8'h36;
  localparam logic [DATA_W-1:0] CH_HASH = 8'h23;
  localparam logic [DATA_W-1:0] CH_LF   = 8'h0A;
  localparam logic [DATA_W-1:0] CH_0    = 8'h30;
  localparam logic [DATA_W-1:0] CH_9    = 8'h39;

  localparam logic [SAMPLE_W-1:0] NUM_MAX = 16'hFFFF;
  localparam logic [DIM_W-1:0]    DIM_SAT = 13'h1FFF;

  // Bytes per pixel for one-byte and two-byte samples.
  localparam logic [2:0] BYTES_NARROW = 3'd3;
  localparam logic [2:0] BYTES_WIDE   = 3'd6;

  typedef enum logic [2:0] {
    PH_MAGIC0,
    PH_MAGIC1,
    PH_HEADER,
    PH_PIXELS,
    PH_IDLE
  } phase_t;

endpackage

`default_nettype wire

// File: design/ppm_if.sv
// Valid/ready channel interfaces for the PPM P6 stream parser:
// the byte input channel and the result channel. Depends on ppm_pkg.
`default_nettype none

interface ppm_byte_if;
  import ppm_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface ppm_res_if;
  import ppm_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [DIM_W-1:0]    width;
  logic [DIM_W-1:0]    height;
  logic [SAMPLE_W-1:0] max_value;
  logic [SAMPLE_W-1:0] red;
  logic [SAMPLE_W-1:0] green;
  logic [SAMPLE_W-1:0] blue;
  logic [COORD_W-1:0]  column;
  logic [COORD_W-1:0]  row;
  logic                last;

  modport source (output valid, output kind, output width, output height,
                  output max_value, output red, output green, output blue,
                  output column, output row, output last, input ready);
  modport sink   (input valid, input kind, input width, input height,
                  input max_value, input red, input green, input blue,
                  input column, input row, input last, output ready);
endinterface

`default_nettype wire

// File: design/ppm_p6_stream_parser.sv
// Top level of the PPM P6 stream parser: header and raster decoding.
// Depends on ppm_pkg and the channel interfaces in ppm_if.sv.
//
// Usage: the file stream enters one byte per transfer on in_ch. Each
// byte updates the running parse state, and a byte that completes the
// header, a pixel or an error loads the single output register on
// out_ch; its result appears there in the cycle after its transfer.
// One byte is taken every cycle while in_ch.ready is high, and
// in_ch.ready drops only while a result sits in the output register and
// out_ch.ready is low, so a stalled receiver holds the result and the
// input side waits with it. Results: one header (or a size error) after
// maxval and its separator, then one pixel per 3 bytes (maxval below
// 256) or 6 bytes. A bad magic number, a size error, an empty image or
// the last pixel ends the image; later bytes are taken and dropped.
// Synchronous reset (rst_n low) returns the parser to waiting for the
// magic number and empties the output register.
`default_nettype none

module ppm_p6_stream_parser #(
  parameter int MAX_DIM = 4096
) (
  input  wire          clk,
  input  wire          rst_n,
  ppm_byte_if.sink     in_ch,
  ppm_res_if.source    out_ch
);
  import ppm_pkg::*;

  // Held dimensions and pixel counters only need to reach MAX_DIM.
  localparam int HW    = $clog2(MAX_DIM + 1);
  localparam int EXT_W = HW + DIM_W;
  localparam logic [SAMPLE_W:0] MAX_DIM_V = (SAMPLE_W + 1)'(MAX_DIM);

  phase_t              phase_r, phase_nxt;
  logic                magic_ok_r, magic_ok_nxt;
  logic [FIELD_W-1:0]  field_r, field_nxt;
  logic                in_comment_r, in_comment_nxt;
  logic                in_number_r, in_number_nxt;
  logic [SAMPLE_W-1:0] acc_r, acc_nxt;
  logic [SAMPLE_W-1:0] raw_w_r, raw_w_nxt;
  logic [SAMPLE_W-1:0] raw_h_r, raw_h_nxt;
  logic [SAMPLE_W-1:0] max_r, max_nxt;
  logic [HW-1:0]       width_r, width_nxt;
  logic [HW-1:0]       height_r, height_nxt;
  logic                wide_r, wide_nxt;
  logic [2:0]          bip_r, bip_nxt;
  logic [SAMPLE_W-1:0] hold_r [3];
  logic [SAMPLE_W-1:0] hold_nxt [3];
  logic [HW-1:0]       col_r, col_nxt;
  logic [HW-1:0]       row_r, row_nxt;

  // Output register.
  logic                out_valid_r;
  logic [KIND_W-1:0]   out_kind_r;
  logic [DIM_W-1:0]    out_width_r, out_height_r;
  logic [SAMPLE_W-1:0] out_max_r, out_red_r, out_green_r, out_blue_r;
  logic [COORD_W-1:0]  out_col_r, out_row_r;
  logic                out_last_r;

  // Result computed from the byte being transferred.
  logic                res_fire;
  logic [KIND_W-1:0]   res_kind;
  logic [DIM_W-1:0]    res_width, res_height;
  logic [SAMPLE_W-1:0] res_max, res_red, res_green, res_blue;
  logic [COORD_W-1:0]  res_col, res_row;
  logic                res_last;

  logic                in_fire;
  logic [DATA_W-1:0]   b;
  logic                is_digit;
  logic [19:0]         acc_prod;
  logic [SAMPLE_W-1:0] acc_sat;
  logic                size_err;
  logic [DIM_W-1:0]    sat_w, sat_h;
  logic [HW:0]         col_inc, row_inc;
  logic                pix_last;
  logic [2:0]          bip_inc;
  logic [1:0]          slot;
  logic [EXT_W-1:0]    width_ext, height_ext, col_ext, row_ext;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign is_digit    = (b >= CH_0) && (b <= CH_9);

  // Decimal accumulate with saturation at 65535.
  assign acc_prod = {4'd0, acc_r} * 20'd10 + {16'd0, b[3:0]};
  assign acc_sat  = (acc_prod > {4'd0, NUM_MAX}) ? NUM_MAX : acc_prod[SAMPLE_W-1:0];

  assign size_err = ({1'b0, raw_w_r} > MAX_DIM_V) || ({1'b0, raw_h_r} > MAX_DIM_V);
  assign sat_w    = (raw_w_r > SAMPLE_W'(DIM_SAT)) ? DIM_SAT : raw_w_r[DIM_W-1:0];
  assign sat_h    = (raw_h_r > SAMPLE_W'(DIM_SAT)) ? DIM_SAT : raw_h_r[DIM_W-1:0];

  assign col_inc  = {1'b0, col_r} + (HW + 1)'(1);
  assign row_inc  = {1'b0, row_r} + (HW + 1)'(1);
  assign pix_last = (col_inc == {1'b0, width_r}) && (row_inc == {1'b0, height_r});
  assign bip_inc  = bip_r + 3'd1;
  assign slot     = wide_r ? bip_r[2:1] : bip_r[1:0];

  assign width_ext  = EXT_W'(width_r);
  assign height_ext = EXT_W'(height_r);
  assign col_ext    = EXT_W'(col_r);
  assign row_ext    = EXT_W'(row_r);

  always_comb begin
    phase_nxt      = phase_r;
    magic_ok_nxt   = magic_ok_r;
    field_nxt      = field_r;
    in_comment_nxt = in_comment_r;
    in_number_nxt  = in_number_r;
    acc_nxt        = acc_r;
    raw_w_nxt      = raw_w_r;
    raw_h_nxt      = raw_h_r;
    max_nxt        = max_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    wide_nxt       = wide_r;
    bip_nxt        = bip_r;
    hold_nxt       = hold_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    res_fire       = 1'b0;
    res_kind       = KIND_HEADER;
    res_width      = '0;
    res_height     = '0;
    res_max        = '0;
    res_red        = '0;
    res_green      = '0;
    res_blue       = '0;
    res_col        = '0;
    res_row        = '0;
    res_last       = 1'b0;

    if (in_fire) begin
      unique case (phase_r)
        PH_MAGIC0: begin
          magic_ok_nxt = (b == CH_P);
          phase_nxt    = PH_MAGIC1;
        end
        PH_MAGIC1: begin
          if (magic_ok_r && (b == CH_6)) begin
            phase_nxt = PH_HEADER;
          end else begin
            res_fire  = 1'b1;
            res_kind  = KIND_BAD_MAGIC;
            phase_nxt = PH_IDLE;
          end
        end
        PH_HEADER: begin
          if (in_number_r) begin
            if (is_digit) begin
              acc_nxt = acc_sat;
            end else begin
              // The byte that ends a number is consumed, even a '#'.
              in_number_nxt = 1'b0;
              case (field_r)
                FLD_WIDTH: begin
                  raw_w_nxt = acc_r;
                  field_nxt = FLD_HEIGHT;
                end
                FLD_HEIGHT: begin
                  raw_h_nxt = acc_r;
                  field_nxt = FLD_MAXVAL;
                end
                default: begin
                  max_nxt   = acc_r;
                  field_nxt = FLD_DONE;
                  res_fire  = 1'b1;
                  res_max   = acc_r;
                  if (size_err) begin
                    res_kind   = KIND_SIZE_ERR;
                    res_width  = sat_w;
                    res_height = sat_h;
                    phase_nxt  = PH_IDLE;
                  end else begin
                    res_kind   = KIND_HEADER;
                    res_width  = raw_w_r[DIM_W-1:0];
                    res_height = raw_h_r[DIM_W-1:0];
                    width_nxt  = raw_w_r[HW-1:0];
                    height_nxt = raw_h_r[HW-1:0];
                    wide_nxt   = (acc_r[SAMPLE_W-1:DATA_W] != '0);
                    bip_nxt    = '0;
                    col_nxt    = '0;
                    row_nxt    = '0;
                    phase_nxt  = ((raw_w_r == '0) || (raw_h_r == '0)) ? PH_IDLE : PH_PIXELS;
                  end
                end
              endcase
            end
          end else if (in_comment_r) begin
            if (b == CH_LF) begin
              in_comment_nxt = 1'b0;
            end
          end else if (is_digit) begin
            in_number_nxt = 1'b1;
            acc_nxt       = {12'd0, b[3:0]};
          end else if (b == CH_HASH) begin
            in_comment_nxt = 1'b1;
          end
        end
        PH_PIXELS: begin
          if (wide_r) begin
            if (!bip_r[0]) begin
              hold_nxt[slot] = {b, 8'h00};
            end else begin
              hold_nxt[slot] = {hold_r[slot][SAMPLE_W-1:DATA_W], b};
            end
          end else begin
            hold_nxt[slot] = {8'h00, b};
          end
          if (bip_inc == (wide_r ? BYTES_WIDE : BYTES_NARROW)) begin
            bip_nxt    = '0;
            res_fire   = 1'b1;
            res_kind   = KIND_PIXEL;
            res_width  = width_ext[DIM_W-1:0];
            res_height = height_ext[DIM_W-1:0];
            res_max    = max_r;
            res_red    = hold_nxt[0];
            res_green  = hold_nxt[1];
            res_blue   = hold_nxt[2];
            res_col    = col_ext[COORD_W-1:0];
            res_row    = row_ext[COORD_W-1:0];
            res_last   = pix_last;
            if (pix_last) begin
              phase_nxt = PH_IDLE;
            end else if (col_inc >= {1'b0, width_r}) begin
              col_nxt = '0;
              row_nxt = row_inc[HW-1:0];
            end else begin
              col_nxt = col_inc[HW-1:0];
            end
          end else begin
            bip_nxt = bip_inc;
          end
        end
        PH_IDLE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_MAGIC0;
      magic_ok_r   <= 1'b0;
      field_r      <= FLD_WIDTH;
      in_comment_r <= 1'b0;
      in_number_r  <= 1'b0;
      acc_r        <= '0;
      raw_w_r      <= '0;
      raw_h_r      <= '0;
      max_r        <= '0;
      width_r      <= '0;
      height_r     <= '0;
      wide_r       <= 1'b0;
      bip_r        <= '0;
      hold_r       <= '{default: '0};
      col_r        <= '0;
      row_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      magic_ok_r   <= magic_ok_nxt;
      field_r      <= field_nxt;
      in_comment_r <= in_comment_nxt;
      in_number_r  <= in_number_nxt;
      acc_r        <= acc_nxt;
      raw_w_r      <= raw_w_nxt;
      raw_h_r      <= raw_h_nxt;
      max_r        <= max_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      wide_r       <= wide_nxt;
      bip_r        <= bip_nxt;
      hold_r       <= hold_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      // A transfer in always finds the output register free or draining.
      if (in_fire) begin
        out_valid_r <= res_fire;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_fire) begin
      out_kind_r   <= res_kind;
      out_width_r  <= res_width;
      out_height_r <= res_height;
      out_max_r    <= res_max;
      out_red_r    <= res_red;
      out_green_r  <= res_green;
      out_blue_r   <= res_blue;
      out_col_r    <= res_col;
      out_row_r    <= res_row;
      out_last_r   <= res_last;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = out_kind_r;
  assign out_ch.width     = out_width_r;
  assign out_ch.height    = out_height_r;
  assign out_ch.max_value = out_max_r;
  assign out_ch.red       = out_red_r;
  assign out_ch.green     = out_green_r;
  assign out_ch.blue      = out_blue_r;
  assign out_ch.column    = out_col_r;
  assign out_ch.row       = out_row_r;
  assign out_ch.last      = out_last_r;

  // The last pixel of an image always leaves the parser finished.
  a_last_ends_image: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (phase_r == PH_IDLE))
    else $error("last pixel emitted while parser still active");

  // The byte position within a pixel stays below the pixel size.
  a_bip_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PIXELS) |-> (bip_r < (wide_r ? BYTES_WIDE : BYTES_NARROW)))
    else $error("byte position within pixel out of range");

  // A number and a comment are never open at once.
  a_number_comment: assert property (@(posedge clk) disable iff (!rst_n)
    in_number_r |-> !in_comment_r)
    else $error("number and comment both open");

  // A held result blocks the input side until it is taken.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted while result register is stalled");

endmodule

`default_nettype wire

// File: tb/ppm_parse_checker.sv
// Checker for the PPM P6 stream parser: predicts each result from the byte transfers
// and compares it with the result transfers. Depends on ppm_pkg and ppm_if.sv.
`timescale 1ns / 100ps

module ppm_parse_checker #(
  parameter int MAX_DIM = 4096
) (
  input  wire  clk,
  input  wire  rst_n,
  ppm_byte_if  byte_ch,
  ppm_res_if   res_ch,
  output int   error_count,
  output int   pending,
  output int   checked
);
  import ppm_pkg::*;

  localparam int unsigned WIDE_LIMIT = 256;
  localparam int          REPORT_MAX = 10;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [SAMPLE_W-1:0] max_value;
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic [COORD_W-1:0]  column;
    logic [COORD_W-1:0]  row;
    logic                last;
  } ppm_result_t;

  ppm_result_t expected_results [$];
  ppm_result_t seen_result;
  ppm_result_t want_result;

  // Parser state as the byte stream has driven it so far.
  phase_t               phase;
  logic [FIELD_W-1:0]   field;
  bit                   magic_ok;
  bit                   in_comment;
  bit                   in_number;
  int unsigned          number_acc;
  int unsigned          raw_width;
  int unsigned          raw_height;
  int unsigned          raw_max;
  logic [DIM_W-1:0]     image_width;
  logic [DIM_W-1:0]     image_height;
  bit                   wide_samples;
  int unsigned          byte_in_pixel;
  logic [SAMPLE_W-1:0]  sample_hold [3];
  int unsigned          column_count;
  int unsigned          row_count;

  task automatic parse_byte(input logic [DATA_W-1:0] b);
    ppm_result_t r;
    bit          digit;
    int unsigned per_pixel;
    int unsigned slot;
    bit          last_pixel;
    r = '0;
    digit = (b >= CH_0) && (b <= CH_9);
    case (phase)
      PH_MAGIC0: begin
        magic_ok = (b == CH_P);
        phase = PH_MAGIC1;
      end
      PH_MAGIC1: begin
        if (magic_ok && b == CH_6) begin
          phase = PH_HEADER;
        end else begin
          r.kind = KIND_BAD_MAGIC;
          expected_results.push_back(r);
          phase = PH_IDLE;
        end
      end
      PH_HEADER: begin
        if (in_number) begin
          if (digit) begin
            number_acc = number_acc * 10 + (b - CH_0);
            if (number_acc > NUM_MAX) number_acc = NUM_MAX;
          end else begin
            // The terminator is swallowed here, even when it is a '#'.
            in_number = 1'b0;
            case (field)
              FLD_WIDTH: begin
                raw_width = number_acc;
                field = FLD_HEIGHT;
              end
              FLD_HEIGHT: begin
                raw_height = number_acc;
                field = FLD_MAXVAL;
              end
              default: begin
                raw_max = number_acc;
                field = FLD_DONE;
                if (raw_width > MAX_DIM || raw_height > MAX_DIM) begin
                  r.kind = KIND_SIZE_ERR;
                  r.width = (raw_width > DIM_SAT) ? DIM_SAT : raw_width[DIM_W-1:0];
                  r.height = (raw_height > DIM_SAT) ? DIM_SAT : raw_height[DIM_W-1:0];
                  r.max_value = raw_max[SAMPLE_W-1:0];
                  phase = PH_IDLE;
                end else begin
                  image_width = raw_width[DIM_W-1:0];
                  image_height = raw_height[DIM_W-1:0];
                  wide_samples = (raw_max >= WIDE_LIMIT);
                  byte_in_pixel = 0;
                  column_count = 0;
                  row_count = 0;
                  r.kind = KIND_HEADER;
                  r.width = image_width;
                  r.height = image_height;
                  r.max_value = raw_max[SAMPLE_W-1:0];
                  if (raw_width == 0 || raw_height == 0) phase = PH_IDLE;
                  else phase = PH_PIXELS;
                end
                expected_results.push_back(r);
              end
            endcase
          end
        end else if (in_comment) begin
          if (b == CH_LF) in_comment = 1'b0;
        end else if (digit) begin
          in_number = 1'b1;
          number_acc = b - CH_0;
        end else if (b == CH_HASH) begin
          in_comment = 1'b1;
        end
      end
      PH_PIXELS: begin
        if (wide_samples) begin
          slot = byte_in_pixel >> 1;
          if (byte_in_pixel[0] == 1'b0) sample_hold[slot] = {b, 8'h00};
          else sample_hold[slot][7:0] = b;
          per_pixel = BYTES_WIDE;
        end else begin
          sample_hold[byte_in_pixel] = {8'h00, b};
          per_pixel = BYTES_NARROW;
        end
        byte_in_pixel++;
        if (byte_in_pixel == per_pixel) begin
          byte_in_pixel = 0;
          last_pixel = (column_count + 1 == image_width) && (row_count + 1 == image_height);
          r.kind = KIND_PIXEL;
          r.width = image_width;
          r.height = image_height;
          r.max_value = raw_max[SAMPLE_W-1:0];
          r.red = sample_hold[0];
          r.green = sample_hold[1];
          r.blue = sample_hold[2];
          r.column = column_count[COORD_W-1:0];
          r.row = row_count[COORD_W-1:0];
          r.last = last_pixel;
          expected_results.push_back(r);
          if (last_pixel) begin
            phase = PH_IDLE;
          end else if (column_count + 1 >= image_width) begin
            column_count = 0;
            row_count++;
          end else begin
            column_count++;
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      error_count = 0;
      checked = 0;
      phase = PH_MAGIC0;
      field = FLD_WIDTH;
      magic_ok = 1'b0;
      in_comment = 1'b0;
      in_number = 1'b0;
      number_acc = 0;
      raw_width = 0;
      raw_height = 0;
      raw_max = 0;
      image_width = '0;
      image_height = '0;
      wide_samples = 1'b0;
      byte_in_pixel = 0;
      sample_hold[0] = '0;
      sample_hold[1] = '0;
      sample_hold[2] = '0;
      column_count = 0;
      row_count = 0;
      expected_results.delete();
    end else begin
      // A result transfer always belongs to a byte transfer of an earlier cycle.
      if (res_ch.valid && res_ch.ready) begin
        seen_result.kind = res_ch.kind;
        seen_result.width = res_ch.width;
        seen_result.height = res_ch.height;
        seen_result.max_value = res_ch.max_value;
        seen_result.red = res_ch.red;
        seen_result.green = res_ch.green;
        seen_result.blue = res_ch.blue;
        seen_result.column = res_ch.column;
        seen_result.row = res_ch.row;
        seen_result.last = res_ch.last;
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("ERROR %0t: result transfer with no result pending, kind=%0d",
                     $realtime, seen_result.kind);
        end else begin
          want_result = expected_results.pop_front();
          checked++;
          if (seen_result !== want_result) begin
            error_count++;
            if (error_count <= REPORT_MAX) begin
              $display("ERROR %0t: result %0d expected kind=%0d w=%0d h=%0d max=%0d",
                       $realtime, checked, want_result.kind, want_result.width,
                       want_result.height, want_result.max_value);
              $display("  rgb=%0h,%0h,%0h x=%0d y=%0d last=%0b", want_result.red,
                       want_result.green, want_result.blue, want_result.column,
                       want_result.row, want_result.last);
              $display("  got kind=%0d w=%0d h=%0d max=%0d rgb=%0h,%0h,%0h x=%0d y=%0d last=%0b",
                       seen_result.kind, seen_result.width, seen_result.height,
                       seen_result.max_value, seen_result.red, seen_result.green,
                       seen_result.blue, seen_result.column, seen_result.row,
                       seen_result.last);
            end
          end
        end
      end
      if (byte_ch.valid && byte_ch.ready) parse_byte(byte_ch.data_byte);
    end
    pending = expected_results.size();
  end

endmodule

// File: tb/tb_ppm_p6_stream_parser.sv
// Testbench top for the PPM P6 stream parser: builds one file stream, drives it in
// bursts against a stalling receiver and reports the verdict. Depends on ppm_pkg,
// ppm_if.sv, the parser and ppm_parse_checker.
`timescale 1ns / 100ps

module tb_ppm_p6_stream_parser;
  import ppm_pkg::*;

  localparam int MAX_DIM = 4096;
  localparam int WAIT_LIMIT = 100000;
  localparam int NOISE_BYTES = 1900;
  localparam int RASTER_TARGET = 1900;

  localparam logic [DATA_W-1:0] CH_SP  = 8'h20;
  localparam logic [DATA_W-1:0] CH_TAB = 8'h09;
  localparam logic [DATA_W-1:0] CH_CR  = 8'h0D;

  typedef enum {SC_BAD_MAGIC, SC_SIZE_ERR, SC_EMPTY, SC_LINE, SC_IMAGE} scenario_t;
  typedef enum {RX_OPEN, RX_COIN, RX_CHOKED, RX_LIGHT} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ppm_byte_if in_if ();
  ppm_res_if  out_if ();

  int errors;
  int pending;
  int checked;

  logic [DATA_W-1:0] file_bytes [$];
  scenario_t         scenario;
  int unsigned       img_width;
  int unsigned       img_height;
  int unsigned       img_max;

  ppm_p6_stream_parser #(.MAX_DIM(MAX_DIM)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  ppm_parse_checker #(.MAX_DIM(MAX_DIM)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_ch     (in_if),
    .res_ch      (out_if),
    .error_count (errors),
    .pending     (pending),
    .checked     (checked)
  );

  always #1 clk = ~clk;

  // A byte that neither extends nor starts a number and does not open a comment.
  function automatic logic [DATA_W-1:0] filler_byte();
    logic [DATA_W-1:0] b;
    case ($urandom_range(0, 5))
      0: b = CH_SP;
      1: b = CH_TAB;
      2: b = CH_LF;
      3: b = CH_CR;
      default: begin
        do b = DATA_W'($urandom_range(0, 255));
        while ((b >= CH_0 && b <= CH_9) || b == CH_HASH);
      end
    endcase
    return b;
  endfunction

  function automatic void add_gap(input int max_len);
    int n;
    int i;
    logic [DATA_W-1:0] b;
    n = $urandom_range(0, max_len);
    for (i = 0; i < n; i++) file_bytes.push_back(filler_byte());
    if ($urandom_range(0, 3) == 0) begin
      // Digits and '#' inside a comment must not count.
      file_bytes.push_back(CH_HASH);
      n = $urandom_range(0, 8);
      for (i = 0; i < n; i++) begin
        do b = DATA_W'($urandom_range(0, 255)); while (b == CH_LF);
        if ($urandom_range(0, 2) == 0) b = DATA_W'($urandom_range(CH_0, CH_9));
        file_bytes.push_back(b);
      end
      file_bytes.push_back(CH_LF);
    end
  endfunction

  function automatic void add_number(input int unsigned value);
    string digits;
    int    zeros;
    int    i;
    zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    for (i = 0; i < zeros; i++) file_bytes.push_back(CH_0);
    digits = $sformatf("%0d", value);
    for (i = 0; i < digits.len(); i++) file_bytes.push_back(digits[i]);
    // A '#' right after a number ends it and opens no comment.
    if ($urandom_range(0, 3) == 0) file_bytes.push_back(CH_HASH);
    else file_bytes.push_back(filler_byte());
  endfunction

  function automatic void add_header(input int unsigned w, input int unsigned h,
                                     input int unsigned m);
    file_bytes.push_back(CH_P);
    file_bytes.push_back(CH_6);
    add_gap(3);
    add_number(w);
    add_gap(2);
    add_number(h);
    add_gap(2);
    add_number(m);
    img_width = w;
    img_height = h;
    img_max = m;
  endfunction

  function automatic void add_raw(input int n, input bit extremes);
    int i;
    for (i = 0; i < n; i++) begin
      if (extremes && i < 6) file_bytes.push_back(8'h00);
      else if (extremes && i < 12) file_bytes.push_back(8'hFF);
      else file_bytes.push_back(DATA_W'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void build_stream();
    int unsigned w;
    int unsigned h;
    int unsigned m;
    int          per_pixel;
    int          sel;
    logic [DATA_W-1:0] b0;
    logic [DATA_W-1:0] b1;
    sel = $urandom_range(0, 15);
    if (sel == 0) scenario = SC_BAD_MAGIC;
    else if (sel == 1) scenario = SC_SIZE_ERR;
    else if (sel == 2) scenario = SC_EMPTY;
    else if (sel == 3) scenario = SC_LINE;
    else scenario = SC_IMAGE;
    case (scenario)
      SC_BAD_MAGIC: begin
        case ($urandom_range(0, 2))
          0: begin
            b0 = CH_P;
            do b1 = DATA_W'($urandom_range(0, 255)); while (b1 == CH_6);
          end
          1: begin
            do b0 = DATA_W'($urandom_range(0, 255)); while (b0 == CH_P);
            b1 = CH_6;
          end
          default: begin
            do begin
              b0 = DATA_W'($urandom_range(0, 255));
              b1 = DATA_W'($urandom_range(0, 255));
            end while (b0 == CH_P && b1 == CH_6);
          end
        endcase
        file_bytes.push_back(b0);
        file_bytes.push_back(b1);
        add_raw(NOISE_BYTES, 1'b0);
      end
      SC_SIZE_ERR: begin
        case ($urandom_range(0, 3))
          0: begin w = MAX_DIM + 1; h = $urandom_range(1, MAX_DIM); end
          1: begin w = $urandom_range(1, MAX_DIM); h = MAX_DIM + 1; end
          2: begin w = 99999999; h = $urandom_range(0, 99999); end
          default: begin
            w = $urandom_range(MAX_DIM + 1, 65535);
            h = $urandom_range(MAX_DIM + 1, 65535);
          end
        endcase
        add_header(w, h, $urandom_range(0, 70000));
        add_raw(NOISE_BYTES, 1'b0);
      end
      SC_EMPTY: begin
        case ($urandom_range(0, 2))
          0: begin w = 0; h = $urandom_range(1, 100); end
          1: begin w = $urandom_range(1, 100); h = 0; end
          default: begin w = 0; h = 0; end
        endcase
        add_header(w, h, $urandom_range(0, 65535));
        add_raw(NOISE_BYTES, 1'b0);
      end
      SC_LINE: begin
        // A header right at the dimension limit; the raster stops well before its end.
        if ($urandom_range(0, 1) == 0) begin w = MAX_DIM; h = 1; end
        else begin w = 1; h = MAX_DIM; end
        add_header(w, h, 255);
        add_raw(RASTER_TARGET, 1'b1);
      end
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          case ($urandom_range(0, 3))
            0: m = 0;
            1: m = 1;
            2: m = 255;
            default: m = $urandom_range(2, 254);
          endcase
          per_pixel = BYTES_NARROW;
        end else begin
          case ($urandom_range(0, 3))
            0: m = 256;
            1: m = 65535;
            2: m = 70000;
            default: m = $urandom_range(257, 65534);
          endcase
          per_pixel = BYTES_WIDE;
        end
        w = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, 48);
        h = (RASTER_TARGET / per_pixel) / w;
        if (h == 0) h = 1;
        add_header(w, h, m);
        add_raw(w * h * per_pixel, 1'b1);
        add_raw($urandom_range(0, 20), 1'b0);
      end
    endcase
  endfunction

  // Receiver: ready follows one of four patterns, picked anew at random after each run.
  initial begin
    rx_mode_t mode;
    int       len;
    out_if.ready = 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      len = $urandom_range(8, 64);
      repeat (len) begin
        @(negedge clk);
        case (mode)
          RX_OPEN:   out_if.ready <= 1'b1;
          RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
          RX_CHOKED: out_if.ready <= ($urandom_range(0, 3) == 0);
          default:   out_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    int idx;
    int burst;
    int gap;
    int k;
    int waited;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    img_width = 0;
    img_height = 0;
    img_max = 0;
    build_stream();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    idx = 0;
    while (idx < file_bytes.size()) begin
      burst = $urandom_range(1, 48);
      for (k = 0; k < burst && idx < file_bytes.size(); k++) begin
        in_if.valid <= 1'b1;
        in_if.data_byte <= file_bytes[idx];
        idx++;
        // Hold the byte until its transfer.
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        @(negedge clk);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_if.valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < WAIT_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (4) @(negedge clk);

    $display("Stream of kind %s: %0d bytes sent, %0d results compared.",
             scenario.name(), file_bytes.size(), checked);
    $display("Header numbers: width %0d, height %0d, maxval %0d; %0d results left.",
             img_width, img_height, img_max, pending);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding.", pending);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
